// File: sv/tcs_pkg.sv
// Shared types, constants and letter table for the threshold consensus site core.
package tcs_pkg;

  // Threshold format: unsigned Q16, 17 bits so that 1.0 fits
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned THR_W     = 17;
  localparam logic [THR_W-1:0] Q16_ONE = 17'h1_0000;

  // Configuration port geometry
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_GAPS       = 2'd1;
  localparam logic [1:0] REG_AMBIG      = 2'd2;
  localparam logic [1:0] REG_SEQ_TOTAL  = 2'd3;

  // Output characters
  localparam logic [7:0] GAP_CODE  = 8'h2D;  // '-'
  localparam logic [7:0] MASK_CODE = 8'h58;  // 'X'

  // Configuration seen by the pipeline stages
  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic             gaps_allowed;
    logic             ambiguities_on;
  } cfg_t;

  // IUPAC letter of a base set: bit0 A, bit1 C, bit2 G, bit3 T
  function automatic logic [7:0] iupac_letter(input logic [3:0] set);
    logic [7:0] letter;
    case (set)
      4'h0: letter = GAP_CODE;
      4'h1: letter = 8'h41;  // 'A'
      4'h2: letter = 8'h43;  // 'C'
      4'h3: letter = 8'h4D;  // 'M'
      4'h4: letter = 8'h47;  // 'G'
      4'h5: letter = 8'h52;  // 'R'
      4'h6: letter = 8'h53;  // 'S'
      4'h7: letter = 8'h56;  // 'V'
      4'h8: letter = 8'h54;  // 'T'
      4'h9: letter = 8'h57;  // 'W'
      4'hA: letter = 8'h59;  // 'Y'
      4'hB: letter = 8'h48;  // 'H'
      4'hC: letter = 8'h4B;  // 'K'
      4'hD: letter = 8'h44;  // 'D'
      4'hE: letter = 8'h42;  // 'B'
      default: letter = 8'h4E;  // 'N'
    endcase
    return letter;
  endfunction

endpackage

// File: sv/tcs_prep.sv
// Stage 1: base sum, gap count, column total and pairwise count order.
module tcs_prep #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned SEQ_W      = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [3:0][COUNT_BITS-1:0]  cnt_i,
  input  logic [SEQ_W-1:0]            seq_total_i,
  input  logic                        gaps_allowed_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [3:0][COUNT_BITS-1:0]  cnt_o,
  output logic [5:0]                  ahead_o,
  output logic [COUNT_BITS+1:0]       total_o,
  output logic [SEQ_W-1:0]            gap_o,
  output logic                        err_o,
  output logic                        gap_all_o
);

  localparam int unsigned SUM_W = COUNT_BITS + 2;

  logic                       valid_r;
  logic [3:0][COUNT_BITS-1:0] cnt_r;
  logic [5:0]                 ahead_r;
  logic [SUM_W-1:0]           total_r;
  logic [SEQ_W-1:0]           gap_r;
  logic                       err_r;
  logic                       gap_all_r;

  logic [SUM_W-1:0]           sum;
  logic [SUM_W-1:0]           seq_ext;
  logic                       err_nxt;
  logic [SEQ_W-1:0]           gap_nxt;
  logic [SUM_W-1:0]           total_nxt;
  logic [5:0]                 ahead_nxt;

  // Sum the bases and derive the gap count, clamped at zero
  always_comb begin
    sum = SUM_W'(cnt_i[0]) + SUM_W'(cnt_i[1]) + SUM_W'(cnt_i[2]) + SUM_W'(cnt_i[3]);
    seq_ext = SUM_W'(seq_total_i);
    err_nxt = sum > seq_ext;
    gap_nxt = err_nxt ? '0 : (seq_total_i - sum[SEQ_W-1:0]);
    // sum plus gap is the sequence count unless the gap was clamped
    total_nxt = (gaps_allowed_i && !err_nxt) ? seq_ext : sum;
  end

  // Pairwise order, lower index ahead on ties
  always_comb begin
    ahead_nxt[0] = cnt_i[0] >= cnt_i[1];
    ahead_nxt[1] = cnt_i[0] >= cnt_i[2];
    ahead_nxt[2] = cnt_i[0] >= cnt_i[3];
    ahead_nxt[3] = cnt_i[1] >= cnt_i[2];
    ahead_nxt[4] = cnt_i[1] >= cnt_i[3];
    ahead_nxt[5] = cnt_i[2] >= cnt_i[3];
  end

  assign ready_o = !valid_r || ready_i;

  // Advance the stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  // Load the payload on each accepted request
  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      cnt_r     <= cnt_i;
      ahead_r   <= ahead_nxt;
      total_r   <= total_nxt;
      gap_r     <= gap_nxt;
      err_r     <= err_nxt;
      gap_all_r <= gap_nxt == seq_total_i;
    end
  end

  assign valid_o   = valid_r;
  assign cnt_o     = cnt_r;
  assign ahead_o   = ahead_r;
  assign total_o   = total_r;
  assign gap_o     = gap_r;
  assign err_o     = err_r;
  assign gap_all_o = gap_all_r;

endmodule

// File: sv/tcs_rank_mul.sv
// Stage 2: rank and sort the bases, prefix sums, threshold times total.
module tcs_rank_mul #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned SEQ_W      = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [3:0][COUNT_BITS-1:0]            cnt_i,
  input  logic [5:0]                            ahead_i,
  input  logic [COUNT_BITS+1:0]                 total_i,
  input  logic [SEQ_W-1:0]                      gap_i,
  input  logic                                  err_i,
  input  logic                                  gap_all_i,
  input  logic [tcs_pkg::THR_W-1:0]             threshold_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [3:0]                            nz_o,
  output logic [3:0][1:0]                       ord_o,
  output logic [2:0][COUNT_BITS+1:0]            acc_o,
  output logic [COUNT_BITS+tcs_pkg::THR_W+1:0]  prod_o,
  output logic [SEQ_W-1:0]                      gap_o,
  output logic                                  err_o,
  output logic                                  gap_all_o,
  output logic                                  gap_gt_top_o
);

  localparam int unsigned SUM_W  = COUNT_BITS + 2;
  localparam int unsigned PROD_W = SUM_W + tcs_pkg::THR_W;

  logic                       valid_r;
  logic [3:0]                 nz_r;
  logic [3:0][1:0]            ord_r;
  logic [2:0][SUM_W-1:0]      acc_r;
  logic [PROD_W-1:0]          prod_r;
  logic [SEQ_W-1:0]           gap_r;
  logic                       err_r;
  logic                       gap_all_r;
  logic                       gap_gt_top_r;

  logic [3:0][1:0]            rank;
  logic [3:0][1:0]            ord_nxt;
  logic [3:0][COUNT_BITS-1:0] sc;
  logic [3:0]                 nz_nxt;
  logic [2:0][SUM_W-1:0]      acc_nxt;
  logic [tcs_pkg::THR_W-1:0]  thr_sat;
  logic [PROD_W-1:0]          prod_nxt;

  // Rank of each base: number of bases ahead of it
  always_comb begin
    rank[0] = 2'(!ahead_i[0]) + 2'(!ahead_i[1]) + 2'(!ahead_i[2]);
    rank[1] = 2'(ahead_i[0])  + 2'(!ahead_i[3]) + 2'(!ahead_i[4]);
    rank[2] = 2'(ahead_i[1])  + 2'(ahead_i[3])  + 2'(!ahead_i[5]);
    rank[3] = 2'(ahead_i[2])  + 2'(ahead_i[4])  + 2'(ahead_i[5]);
  end

  // Place each base at its rank and pick up the sorted counts
  always_comb begin
    ord_nxt = '0;
    for (int r = 0; r < 4; r++) begin
      for (int b = 0; b < 4; b++) begin
        if (rank[b] == 2'(r)) begin
          ord_nxt[r] = 2'(b);
        end
      end
    end
    for (int r = 0; r < 4; r++) begin
      sc[r]     = cnt_i[ord_nxt[r]];
      nz_nxt[r] = sc[r] != '0;
    end
  end

  // Running sums of the sorted counts
  always_comb begin
    acc_nxt[0] = SUM_W'(sc[0]);
    acc_nxt[1] = SUM_W'(sc[0]) + SUM_W'(sc[1]);
    acc_nxt[2] = SUM_W'(sc[0]) + SUM_W'(sc[1]) + SUM_W'(sc[2]);
  end

  // Saturate the threshold at 1.0 and scale the total
  always_comb begin
    thr_sat  = (threshold_i > tcs_pkg::Q16_ONE) ? tcs_pkg::Q16_ONE : threshold_i;
    prod_nxt = PROD_W'(thr_sat) * PROD_W'(total_i);
  end

  assign ready_o = !valid_r || ready_i;

  // Advance the stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  // Load the payload on each accepted request
  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      nz_r         <= nz_nxt;
      ord_r        <= ord_nxt;
      acc_r        <= acc_nxt;
      prod_r       <= prod_nxt;
      gap_r        <= gap_i;
      err_r        <= err_i;
      gap_all_r    <= gap_all_i;
      gap_gt_top_r <= COUNT_BITS'(gap_i) > sc[0];
    end
  end

  assign valid_o      = valid_r;
  assign nz_o         = nz_r;
  assign ord_o        = ord_r;
  assign acc_o        = acc_r;
  assign prod_o       = prod_r;
  assign gap_o        = gap_r;
  assign err_o        = err_r;
  assign gap_all_o    = gap_all_r;
  assign gap_gt_top_o = gap_gt_top_r;

endmodule

// File: sv/tcs_select.sv
// Stage 3: threshold compares, base set choice and consensus letter.
module tcs_select #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned SEQ_W      = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [3:0]                            nz_i,
  input  logic [3:0][1:0]                       ord_i,
  input  logic [2:0][COUNT_BITS+1:0]            acc_i,
  input  logic [COUNT_BITS+tcs_pkg::THR_W+1:0]  prod_i,
  input  logic [SEQ_W-1:0]                      gap_i,
  input  logic                                  err_i,
  input  logic                                  gap_all_i,
  input  logic                                  gap_gt_top_i,
  input  tcs_pkg::cfg_t                         cfg_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [7:0]                            site_code_o,
  output logic                                  count_error_o
);

  localparam int unsigned SUM_W  = COUNT_BITS + 2;
  localparam int unsigned PROD_W = SUM_W + tcs_pkg::THR_W;
  localparam int unsigned CMP_W  = PROD_W + tcs_pkg::FRAC_BITS;

  logic       valid_r;
  logic [7:0] site_code_r;
  logic       count_error_r;

  logic [2:0] reached;
  logic       gap_reached;
  logic [3:0] chosen;
  logic [3:0] set;
  logic       is_gap;
  logic [7:0] code_nxt;

  // Fraction compares: value * 2^16 against threshold * total
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      reached[k] = (CMP_W'(acc_i[k]) << tcs_pkg::FRAC_BITS) >= CMP_W'(prod_i);
    end
    gap_reached = (CMP_W'(gap_i) << tcs_pkg::FRAC_BITS) >= CMP_W'(prod_i);
  end

  // Take bases in rank order until a zero count or the threshold stops it
  always_comb begin
    chosen[0] = nz_i[0];
    chosen[1] = chosen[0] && !reached[0] && nz_i[1];
    chosen[2] = chosen[1] && !reached[1] && nz_i[2];
    chosen[3] = chosen[2] && !reached[2] && nz_i[3];
    set = '0;
    for (int r = 0; r < 4; r++) begin
      if (chosen[r]) begin
        set[ord_i[r]] = 1'b1;
      end
    end
    is_gap = gap_all_i || (cfg_i.gaps_allowed && gap_reached && gap_gt_top_i);
    if (is_gap) begin
      code_nxt = tcs_pkg::GAP_CODE;
    end else if (chosen[1] && !cfg_i.ambiguities_on) begin
      code_nxt = tcs_pkg::MASK_CODE;
    end else begin
      code_nxt = tcs_pkg::iupac_letter(set);
    end
  end

  assign ready_o = !valid_r || ready_i;

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      site_code_r   <= code_nxt;
      count_error_r <= err_i;
    end
  end

  assign valid_o       = valid_r;
  assign site_code_o   = site_code_r;
  assign count_error_o = count_error_r;

endmodule

// File: sv/threshold_consensus_site_core.sv
// Top level of the threshold consensus site core: register file and three-stage pipeline.
//
//   channel   handshake                     payload
//   in        in_valid / in_ready           in_count_a, in_count_c, in_count_g, in_count_t
//   out       out_valid / out_ready         out_site_code, out_count_error
//   config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One column per cycle sustained while out_ready holds high; an accepted column passes
// through the three register stages in order (sum and order, sort and the threshold
// multiply, compares and letter choice) before it shows on out_valid.
// Synchronous active-low reset empties the pipeline and loads register defaults.
// A stage takes a new column whenever it is empty or its successor moves, so a
// stall on out ready backs up one stage at a time; nothing is lost or repeated.
module threshold_consensus_site_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // column counts
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COUNT_BITS-1:0]         in_count_a,
  input  logic [COUNT_BITS-1:0]         in_count_c,
  input  logic [COUNT_BITS-1:0]         in_count_g,
  input  logic [COUNT_BITS-1:0]         in_count_t,
  // consensus result
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_site_code,
  output logic                          out_count_error,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcs_pkg::ADDR_W-1:0]    paddr,
  input  logic [tcs_pkg::DATA_W-1:0]    pwdata,
  output logic [tcs_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned SEQ_W  = (COUNT_BITS < 16) ? COUNT_BITS : 16;
  localparam int unsigned SUM_W  = COUNT_BITS + 2;
  localparam int unsigned PROD_W = SUM_W + tcs_pkg::THR_W;

  tcs_pkg::cfg_t              cfg_r;
  logic [SEQ_W-1:0]           seq_total_r;
  logic                       wr_en;

  logic [3:0][COUNT_BITS-1:0] cnt_in;

  logic                       s1_valid;
  logic                       s1_ready;
  logic [3:0][COUNT_BITS-1:0] s1_cnt;
  logic [5:0]                 s1_ahead;
  logic [SUM_W-1:0]           s1_total;
  logic [SEQ_W-1:0]           s1_gap;
  logic                       s1_err;
  logic                       s1_gap_all;

  logic                       s2_valid;
  logic                       s2_ready;
  logic [3:0]                 s2_nz;
  logic [3:0][1:0]            s2_ord;
  logic [2:0][SUM_W-1:0]      s2_acc;
  logic [PROD_W-1:0]          s2_prod;
  logic [SEQ_W-1:0]           s2_gap;
  logic                       s2_err;
  logic                       s2_gap_all;
  logic                       s2_gap_gt_top;

  // Register writes complete in the access phase
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold      <= tcs_pkg::THR_W'(32768);
      cfg_r.gaps_allowed   <= 1'b0;
      cfg_r.ambiguities_on <= 1'b1;
      seq_total_r          <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        tcs_pkg::REG_THRESHOLD: cfg_r.threshold      <= pwdata[tcs_pkg::THR_W-1:0];
        tcs_pkg::REG_GAPS:      cfg_r.gaps_allowed   <= pwdata[0];
        tcs_pkg::REG_AMBIG:     cfg_r.ambiguities_on <= pwdata[0];
        tcs_pkg::REG_SEQ_TOTAL: seq_total_r          <= pwdata[SEQ_W-1:0];
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (paddr[3:2])
      tcs_pkg::REG_THRESHOLD: prdata = tcs_pkg::DATA_W'(cfg_r.threshold);
      tcs_pkg::REG_GAPS:      prdata = tcs_pkg::DATA_W'(cfg_r.gaps_allowed);
      tcs_pkg::REG_AMBIG:     prdata = tcs_pkg::DATA_W'(cfg_r.ambiguities_on);
      tcs_pkg::REG_SEQ_TOTAL: prdata = tcs_pkg::DATA_W'(seq_total_r);
    endcase
  end

  assign cnt_in = {in_count_t, in_count_g, in_count_c, in_count_a};

  tcs_prep #(
    .COUNT_BITS (COUNT_BITS),
    .SEQ_W      (SEQ_W)
  ) u_prep (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid_i        (in_valid),
    .ready_o        (in_ready),
    .cnt_i          (cnt_in),
    .seq_total_i    (seq_total_r),
    .gaps_allowed_i (cfg_r.gaps_allowed),
    .valid_o        (s1_valid),
    .ready_i        (s1_ready),
    .cnt_o          (s1_cnt),
    .ahead_o        (s1_ahead),
    .total_o        (s1_total),
    .gap_o          (s1_gap),
    .err_o          (s1_err),
    .gap_all_o      (s1_gap_all)
  );

  tcs_rank_mul #(
    .COUNT_BITS (COUNT_BITS),
    .SEQ_W      (SEQ_W)
  ) u_rank_mul (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid_i      (s1_valid),
    .ready_o      (s1_ready),
    .cnt_i        (s1_cnt),
    .ahead_i      (s1_ahead),
    .total_i      (s1_total),
    .gap_i        (s1_gap),
    .err_i        (s1_err),
    .gap_all_i    (s1_gap_all),
    .threshold_i  (cfg_r.threshold),
    .valid_o      (s2_valid),
    .ready_i      (s2_ready),
    .nz_o         (s2_nz),
    .ord_o        (s2_ord),
    .acc_o        (s2_acc),
    .prod_o       (s2_prod),
    .gap_o        (s2_gap),
    .err_o        (s2_err),
    .gap_all_o    (s2_gap_all),
    .gap_gt_top_o (s2_gap_gt_top)
  );

  tcs_select #(
    .COUNT_BITS (COUNT_BITS),
    .SEQ_W      (SEQ_W)
  ) u_select (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid_i       (s2_valid),
    .ready_o       (s2_ready),
    .nz_i          (s2_nz),
    .ord_i         (s2_ord),
    .acc_i         (s2_acc),
    .prod_i        (s2_prod),
    .gap_i         (s2_gap),
    .err_i         (s2_err),
    .gap_all_i     (s2_gap_all),
    .gap_gt_top_i  (s2_gap_gt_top),
    .cfg_i         (cfg_r),
    .valid_o       (out_valid),
    .ready_i       (out_ready),
    .site_code_o   (out_site_code),
    .count_error_o (out_count_error)
  );

endmodule

// File: sv/tcs_checker.sv
// Port-level checker for the threshold consensus site core, with its bind.
module tcs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_site_code,
  input logic       out_count_error
);

  // A result waiting on the consumer stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result keeps its payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_site_code) && $stable(out_count_error))
    else $error("result payload changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Every result is a gap, a mask or an IUPAC nucleotide letter
  a_code_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_site_code == 8'h2D || out_site_code == 8'h58 ||
                   out_site_code == 8'h41 || out_site_code == 8'h43 ||
                   out_site_code == 8'h4D || out_site_code == 8'h47 ||
                   out_site_code == 8'h52 || out_site_code == 8'h53 ||
                   out_site_code == 8'h56 || out_site_code == 8'h54 ||
                   out_site_code == 8'h57 || out_site_code == 8'h59 ||
                   out_site_code == 8'h48 || out_site_code == 8'h4B ||
                   out_site_code == 8'h44 || out_site_code == 8'h42 ||
                   out_site_code == 8'h4E))
    else $error("out_site_code outside the consensus alphabet");

endmodule

bind threshold_consensus_site_core tcs_checker u_tcs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_site_code   (out_site_code),
  .out_count_error (out_count_error)
);
